FILE: design/kuz_pkg.sv
// Package with the S-boxes, GF(2^8) helpers and the round functions of the cipher.
package kuz_pkg;

  localparam int NumRounds = 10;
  localparam int NumKeys = 10;
  localparam int KeyIdxW = 4;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [7:0] LCOEF [16] = '{
    8'd1,8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,
    8'd251,8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148
  };

  function automatic logic [7:0] sbox_inv(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] lin_l(input logic [127:0] v);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(v[8*i +: 8], LCOEF[i]);
    return acc;
  endfunction

  // One register step of the linear layer; sixteen steps give L.
  function automatic logic [127:0] lstep_fwd(input logic [127:0] v);
    return {lin_l(v), v[127:8]};
  endfunction

  function automatic logic [127:0] lstep_inv(input logic [127:0] v);
    logic [127:0] t;
    t = {v[119:0], v[127:120]};
    return {t[127:8], lin_l(t)};
  endfunction

  function automatic logic [127:0] sub_fwd(input logic [127:0] v);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX[v[8*i +: 8]];
    return r;
  endfunction

  function automatic logic [127:0] sub_inv(input logic [127:0] v);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = sbox_inv(v[8*i +: 8]);
    return r;
  endfunction

endpackage

FILE: design/block_cipher_128_round_engine_unit.sv
// Top level of the 128-bit block cipher engine with key expansion.
// Usage: write the 256-bit key as four 64-bit words through cfg_we, cfg_index and
// cfg_data while the engine is idle. Present a block on in_block_low and
// in_block_high with in_kind (0 encrypt, 1 decrypt) and raise in_valid.
// The engine takes one item at a time; in_ready is low while it works.
// Every round runs through one shared linear-layer unit.
// The first item after reset or after a key write first expands the round keys:
// 32 Feistel rounds, each with two linear-layer passes.
// The result is held in an output register until out_ready takes it; a new
// item is not taken before that. Reset clears the key words, the control state
// and marks the round keys as stale; the key store itself is not cleared.
module block_cipher_128_round_engine_unit import kuz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_KC    = 10'b0000000010,
    S_KCW   = 10'b0000000100,
    S_KT    = 10'b0000001000,
    S_KTW   = 10'b0000010000,
    S_RND   = 10'b0000100000,
    S_RNDW  = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_DINV  = 10'b1000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [63:0]   key_r [4];
  logic          keys_ready_r;
  logic [127:0]  rk_r [NumKeys];
  logic [127:0]  a_r, b_r, c_r, x_r;
  logic [5:0]    ci_r;
  logic [KeyIdxW-1:0] ri_r;
  logic          kind_r;
  logic          lu_start, lu_inv, lu_done;
  logic [127:0]  lu_din, lu_dout;

  kuz_lin_unit u_lin (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lu_start),
    .inv   (lu_inv),
    .din   (lu_din),
    .done  (lu_done),
    .dout  (lu_dout)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_result_low  = x_r[63:0];
  assign out_result_high = x_r[127:64];

  always_comb begin
    lu_start  = 1'b0;
    lu_inv    = 1'b0;
    lu_din    = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = keys_ready_r ? (in_kind ? S_DINV : S_RND) : S_KC;
      end
      S_KC: begin
        lu_start  = 1'b1;
        lu_din    = {120'd0, 2'b00, ci_r};
        state_nxt = S_KCW;
      end
      S_KCW: if (lu_done) state_nxt = S_KT;
      S_KT: begin
        lu_start  = 1'b1;
        lu_din    = sub_fwd(a_r ^ c_r);
        state_nxt = S_KTW;
      end
      S_KTW: if (lu_done) begin
        if (ci_r == 6'd32) state_nxt = kind_r ? S_DINV : S_RND;
        else state_nxt = S_KC;
      end
      S_RND: begin
        lu_start  = 1'b1;
        lu_din    = sub_fwd(x_r ^ rk_r[ri_r]);
        state_nxt = S_RNDW;
      end
      S_DINV: begin
        lu_start  = 1'b1;
        lu_inv    = 1'b1;
        lu_din    = x_r ^ rk_r[ri_r];
        state_nxt = S_RNDW;
      end
      S_RNDW: if (lu_done) begin
        if (kind_r) state_nxt = (ri_r == 4'd1) ? S_FIN : S_DINV;
        else state_nxt = (ri_r == 4'd8) ? S_FIN : S_RND;
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      keys_ready_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_data;
        keys_ready_r     <= 1'b0;
      end else if (state_r == S_KTW && lu_done && ci_r == 6'd32) begin
        keys_ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        kind_r <= in_kind;
        x_r    <= {in_block_high, in_block_low};
        ri_r   <= in_kind ? 4'd9 : 4'd0;
        ci_r   <= 6'd1;
        a_r    <= {key_r[1], key_r[0]};
        b_r    <= {key_r[3], key_r[2]};
        rk_r[0] <= {key_r[1], key_r[0]};
        rk_r[1] <= {key_r[3], key_r[2]};
      end
      S_KCW: if (lu_done) c_r <= lu_dout;
      S_KTW: if (lu_done) begin
        a_r  <= lu_dout ^ b_r;
        b_r  <= a_r;
        ci_r <= ci_r + 6'd1;
        if (ci_r[2:0] == 3'd0) begin
          rk_r[ci_r[5:2]]        <= lu_dout ^ b_r;
          rk_r[ci_r[5:2] + 4'd1] <= a_r;
        end
      end
      S_RNDW: if (lu_done) begin
        if (kind_r) begin
          x_r  <= sub_inv(lu_dout);
          ri_r <= ri_r - 4'd1;
        end else begin
          x_r  <= lu_dout;
          ri_r <= ri_r + 4'd1;
        end
      end
      S_FIN: x_r <= x_r ^ rk_r[ri_r];
      default: ;
    endcase
  end

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x_r))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");
  a_keys_before_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND || state_r == S_DINV) |-> keys_ready_r)
    else $error("round started without expanded keys");

endmodule

FILE: design/kuz_lin_unit.sv
// Shared linear-layer unit: applies L or its inverse one byte step per cycle.
module kuz_lin_unit import kuz_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         inv,
  input  logic [127:0] din,
  output logic         done,
  output logic [127:0] dout
);

  logic [127:0] v_r;
  logic [4:0]   cnt_r;
  logic         busy_r;
  logic         inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd15) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= din;
      inv_r <= inv;
    end else if (busy_r) begin
      v_r <= inv_r ? lstep_inv(v_r) : lstep_fwd(v_r);
    end
  end

  assign done = busy_r && (cnt_r == 5'd15);
  assign dout = inv_r ? lstep_inv(v_r) : lstep_fwd(v_r);

endmodule

FILE: tb/sv/tb_block_cipher_128_round_engine_unit.sv
// Testbench for the 128-bit block cipher engine, checked against its own cipher predictor.
`timescale 1ns / 1ps

module tb_block_cipher_128_round_engine_unit;

  localparam logic [1:0] KEY_WORD_0 = 2'd0;
  localparam logic [1:0] KEY_WORD_1 = 2'd1;
  localparam logic [1:0] KEY_WORD_2 = 2'd2;
  localparam logic [1:0] KEY_WORD_3 = 2'd3;
  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
  } block_item_t;

  typedef struct packed {
    logic [63:0] res_lo;
    logic [63:0] res_hi;
  } cipher_out_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [63:0] in_block_low;
  logic [63:0] in_block_high;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;

  block_cipher_128_round_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_block_low(in_block_low), .in_block_high(in_block_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_low(out_result_low), .out_result_high(out_result_high)
  );

  localparam logic [7:0] SUBST [256] = '{
    252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
    233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
    249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
    5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
    235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
    181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
    21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
    50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
    223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
    224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
    167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
    173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
    7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
    225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
    32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
    89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
  };
  localparam logic [7:0] MIX_COEF [16] = '{
    1,148,32,133,16,194,192,1,251,1,192,194,16,133,32,148
  };

  logic [7:0]   subst_inv [256];
  logic [63:0]  key_w [4];
  logic [127:0] round_keys [10];
  bit           keys_stale;

  block_item_t pending_blocks[$];
  cipher_out_t expected_blocks[$];
  int          mismatches;
  int          results_seen;

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h1C3;
    end
    return r;
  endfunction

  function automatic logic [7:0] mix_byte(logic [127:0] v);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 16; i++) acc ^= gf_times(v[8*i +: 8], MIX_COEF[i]);
    return acc;
  endfunction

  function automatic logic [127:0] mix_fwd(logic [127:0] v);
    for (int n = 0; n < 16; n++) v = {mix_byte(v), v[127:8]};
    return v;
  endfunction

  function automatic logic [127:0] mix_back(logic [127:0] v);
    for (int n = 0; n < 16; n++) begin
      v = {v[119:0], v[127:120]};
      v[7:0] = mix_byte(v);
    end
    return v;
  endfunction

  function automatic logic [127:0] subst_fwd(logic [127:0] v);
    for (int i = 0; i < 16; i++) v[8*i +: 8] = SUBST[v[8*i +: 8]];
    return v;
  endfunction

  function automatic logic [127:0] subst_back(logic [127:0] v);
    for (int i = 0; i < 16; i++) v[8*i +: 8] = subst_inv[v[8*i +: 8]];
    return v;
  endfunction

  function automatic void schedule_round_keys();
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] t;
    logic [127:0] c;
    int cidx;
    a = {key_w[1], key_w[0]};
    b = {key_w[3], key_w[2]};
    round_keys[0] = a;
    round_keys[1] = b;
    cidx = 1;
    for (int pair = 1; pair < 5; pair++) begin
      for (int r = 0; r < 8; r++) begin
        c = 128'(cidx[7:0]);
        cidx++;
        t = mix_fwd(subst_fwd(a ^ mix_fwd(c))) ^ b;
        b = a;
        a = t;
      end
      round_keys[2*pair] = a;
      round_keys[2*pair+1] = b;
    end
    keys_stale = 0;
  endfunction

  function automatic cipher_out_t cipher_block(block_item_t it);
    logic [127:0] x;
    cipher_out_t o;
    x = {it.blk_hi, it.blk_lo};
    if (it.kind == KIND_ENCRYPT) begin
      for (int r = 0; r < 9; r++) x = mix_fwd(subst_fwd(x ^ round_keys[r]));
      x ^= round_keys[9];
    end else begin
      x ^= round_keys[9];
      for (int r = 8; r >= 0; r--) x = subst_back(mix_back(x)) ^ round_keys[r];
    end
    o.res_lo = x[63:0];
    o.res_hi = x[127:64];
    return o;
  endfunction

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sender: bursts of items with random gaps between them.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    block_item_t it;
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= 1'b0;
      in_block_low <= '0;
      in_block_high <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        it.kind = in_kind;
        it.blk_lo = in_block_low;
        it.blk_hi = in_block_high;
        if (keys_stale) schedule_round_keys();
        expected_blocks.push_back(cipher_block(it));
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          it = pending_blocks.pop_front();
          in_valid <= 1'b1;
          in_kind <= it.kind;
          in_block_low <= it.blk_lo;
          in_block_high <= it.blk_hi;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern rotates through three modes, with one long hold-off.
  int rx_cycle;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    cipher_out_t exp_o;
    int mode;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_blocks.size() == 0) begin
          $error("unexpected result lo=%h hi=%h", out_result_low, out_result_high);
          mismatches++;
        end else begin
          exp_o = expected_blocks.pop_front();
          if (out_result_low !== exp_o.res_lo) begin
            $error("result_low expected %h actual %h", exp_o.res_lo, out_result_low);
            mismatches++;
          end
          if (out_result_high !== exp_o.res_hi) begin
            $error("result_high expected %h actual %h", exp_o.res_hi, out_result_high);
            mismatches++;
          end
        end
      end
      rx_cycle++;
      if (!hold_done && results_seen == 60) begin
        hold_done = 1;
        hold_left = 2000;
      end
      mode = (rx_cycle / 700) % 3;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (mode == 0) begin
        out_ready <= 1'b1;
      end else if (mode == 1) begin
        out_ready <= 1'($urandom_range(0, 1));
      end else begin
        out_ready <= (rx_cycle % 9) > 5;
      end
    end
  end

  task automatic write_key(logic [1:0] idx, logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    key_w[idx] = v;
    keys_stale = 1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || expected_blocks.size() != 0 || in_valid)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_block(logic kind, logic [63:0] lo, logic [63:0] hi);
    block_item_t it;
    it.kind = kind;
    it.blk_lo = lo;
    it.blk_hi = hi;
    pending_blocks.push_back(it);
  endtask

  task automatic add_directed();
    add_block(KIND_ENCRYPT, '0, '0);
    add_block(KIND_DECRYPT, '0, '0);
    add_block(KIND_ENCRYPT, '1, '1);
    add_block(KIND_DECRYPT, '1, '1);
    add_block(KIND_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    add_block(KIND_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
  endtask

  task automatic add_random(int n);
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < n; i++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0) lo = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 15) == 0) hi = $urandom_range(0, 1) ? '1 : '0;
      add_block(1'($urandom_range(0, 1)), lo, hi);
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) subst_inv[SUBST[i]] = 8'(i);
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    keys_stale = 1;
    mismatches = 0;
    results_seen = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = KEY_WORD_0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The first items run on the all-zero key left by reset.
    add_directed();
    add_random(110);
    wait_drained();

    write_key(KEY_WORD_0, '1);
    write_key(KEY_WORD_1, '1);
    write_key(KEY_WORD_2, '1);
    write_key(KEY_WORD_3, '1);
    add_directed();
    add_random(100);
    wait_drained();

    write_key(KEY_WORD_0, 64'h7766_5544_3322_1100);
    write_key(KEY_WORD_1, 64'hFFEE_DDCC_BBAA_9988);
    write_key(KEY_WORD_2, 64'h1032_5476_98BA_DCFE);
    write_key(KEY_WORD_3, 64'hEFCD_AB89_6745_2301);
    add_directed();
    add_random(100);
    wait_drained();

    // A single word rewritten still forces a new schedule.
    write_key(KEY_WORD_2, '0);
    add_random(100);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      write_key(KEY_WORD_0, {$urandom, $urandom});
      write_key(KEY_WORD_1, {$urandom, $urandom});
      write_key(KEY_WORD_2, {$urandom, $urandom});
      write_key(KEY_WORD_3, {$urandom, $urandom});
      add_random(100);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_blocks.size() != 0) $error("%0d results never arrived", expected_blocks.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
